FILE: hw/rtl/bcf_pkg.sv
package bcf_pkg;

   // graph sizes
   localparam int MAX_VERTICES    = 32;
   localparam int MAX_EDGES       = 64;
   localparam int MAX_ADJ_ENTRIES = 128;

   // list pointer: top bit set marks an empty pointer
   localparam logic [7:0] PTR_NIL = 8'hFF;

   // one emitted edge as kept in the result queue
   typedef struct packed {
      logic [4:0] edge_first;
      logic [4:0] edge_second;
      logic [5:0] component_index;
      logic       last_in_component;
   } rec_type;

   // adjacency load request
   typedef struct packed {
      logic       en;
      logic [4:0] from_vertex;
      logic [4:0] to_vertex;
   } load_type;

   // walk side access to the graph store
   typedef struct packed {
      logic       clear;
      logic       adj_en;
      logic [6:0] adj_addr;
      logic [4:0] head_addr;
   } walk_rd_type;

   // result queue write
   typedef struct packed {
      logic       wr;
      logic [5:0] addr;
      rec_type    data;
   } rec_wr_type;

   // hand over of a finished run to the result queue
   typedef struct packed {
      logic       start;
      logic [6:0] count;
      logic       dropped;
   } flush_type;

endpackage

FILE: hw/rtl/bcf_req_if.sv
interface bcf_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [4:0] from_vertex;
   logic [4:0] to_vertex;

   modport source (output valid, output op, output from_vertex, output to_vertex,
                   input ready);
   modport sink (input valid, input op, input from_vertex, input to_vertex,
                 output ready);
endinterface

FILE: hw/rtl/bcf_rsp_if.sv
interface bcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] edge_first;
   logic [4:0] edge_second;
   logic [5:0] component_index;
   logic       last_in_component;
   logic       last_of_run;
   logic       entries_dropped;

   modport source (output valid, output edge_first, output edge_second,
                   output component_index, output last_in_component,
                   output last_of_run, output entries_dropped, input ready);
   modport sink (input valid, input edge_first, input edge_second,
                 input component_index, input last_in_component,
                 input last_of_run, input entries_dropped, output ready);
endinterface

FILE: hw/rtl/biconnected_component_finder.sv
// channel   dir  fields
// req_chan  in   op, from_vertex, to_vertex
// rsp_chan  out  edge_first, edge_second, component_index, last_in_component,
//                last_of_run, entries_dropped
// csr       in   csr_wr_en, csr_wr_data (num_vertices)
//
// a load item that extends a non-empty list holds off the next request for the link write
// a run item is paced per vertex, per adjacency entry and per popped edge by the single
// walk sequencer and its registered adjacency and edge stack reads
// results stream out after the run, one item at a time, each held until rsp_chan takes it
// reset is synchronous and clears the graph; no clearing pass is needed
module biconnected_component_finder (
   input  logic       clock,
   input  logic       reset,
   bcf_req_if.sink    req_chan,
   bcf_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);

   logic [5:0] nv_ff;
   logic [5:0] vert_count;
   bcf_pkg::load_type    load_req;
   bcf_pkg::walk_rd_type walk_rd;
   bcf_pkg::rec_wr_type  rec_wr;
   bcf_pkg::flush_type   flush;
   logic [7:0] head_ptr;
   logic [4:0] adj_target;
   logic [7:0] adj_next;
   logic       gs_busy;
   logic       gs_dropped;
   logic       q_done;

   // vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 6'd1;
      end else if (csr_wr_en) begin
         nv_ff <= csr_wr_data;
      end
   end

   assign vert_count = (nv_ff > 6'(bcf_pkg::MAX_VERTICES)) ? 6'(bcf_pkg::MAX_VERTICES)
                                                           : nv_ff;

   bcf_graph_store u_graph (
      .clock      (clock),
      .reset      (reset),
      .vert_count (vert_count),
      .load_req   (load_req),
      .walk_rd    (walk_rd),
      .head_ptr   (head_ptr),
      .adj_target (adj_target),
      .adj_next   (adj_next),
      .busy       (gs_busy),
      .dropped    (gs_dropped)
   );

   bcf_search u_search (
      .clock      (clock),
      .reset      (reset),
      .vert_count (vert_count),
      .req_chan   (req_chan),
      .gs_busy    (gs_busy),
      .gs_dropped (gs_dropped),
      .head_ptr   (head_ptr),
      .adj_target (adj_target),
      .adj_next   (adj_next),
      .q_done     (q_done),
      .load_req   (load_req),
      .walk_rd    (walk_rd),
      .rec_wr     (rec_wr),
      .flush      (flush)
   );

   bcf_result_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .rec_wr   (rec_wr),
      .flush    (flush),
      .q_done   (q_done),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: hw/rtl/bcf_graph_store.sv
module bcf_graph_store (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [5:0]            vert_count,
   input  bcf_pkg::load_type     load_req,
   input  bcf_pkg::walk_rd_type  walk_rd,
   output logic [7:0]            head_ptr,
   output logic [4:0]            adj_target,
   output logic [7:0]            adj_next,
   output logic                  busy,
   output logic                  dropped
);

   logic [4:0] tgt_mem [bcf_pkg::MAX_ADJ_ENTRIES];
   logic [7:0] nxt_mem [bcf_pkg::MAX_ADJ_ENTRIES];
   logic [6:0] head_ff [bcf_pkg::MAX_VERTICES];
   logic [6:0] tail_ff [bcf_pkg::MAX_VERTICES];
   logic [31:0] hv_ff, hv_in;
   logic [7:0] count_ff, count_in;
   logic       drop_ff, drop_in;
   logic       link_ff, link_in;
   logic [6:0] link_addr_ff, link_addr_in;
   logic [6:0] link_data_ff, link_data_in;
   logic       accept;
   logic       reject;
   logic [6:0] slot;

   // load admission
   assign reject = ({1'b0, load_req.from_vertex} >= vert_count) ||
                   ({1'b0, load_req.to_vertex} >= vert_count) || count_ff[7];
   assign accept = load_req.en && !reject;
   assign slot   = count_ff[6:0];

   always_comb begin
      hv_in        = hv_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      link_in      = 1'b0;
      link_addr_in = link_addr_ff;
      link_data_in = link_data_ff;
      if (load_req.en && reject) begin
         drop_in = 1'b1;
      end
      if (accept) begin
         count_in = count_ff + 8'd1;
         hv_in[load_req.from_vertex] = 1'b1;
         if (hv_ff[load_req.from_vertex]) begin
            link_in      = 1'b1;
            link_addr_in = tail_ff[load_req.from_vertex];
            link_data_in = slot;
         end
      end
      if (walk_rd.clear) begin
         hv_in    = '0;
         count_in = '0;
         drop_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff    <= '0;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         link_ff  <= 1'b0;
      end else begin
         hv_ff    <= hv_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         link_ff  <= link_in;
      end
      link_addr_ff <= link_addr_in;
      link_data_ff <= link_data_in;
   end

   // list heads and tails
   always_ff @(posedge clock) begin
      if (accept) begin
         tail_ff[load_req.from_vertex] <= slot;
         if (!hv_ff[load_req.from_vertex]) begin
            head_ff[load_req.from_vertex] <= slot;
         end
      end
   end

   // adjacency memories
   always_ff @(posedge clock) begin
      if (accept) begin
         tgt_mem[slot] <= load_req.to_vertex;
      end
      if (accept) begin
         nxt_mem[slot] <= bcf_pkg::PTR_NIL;
      end else if (link_ff) begin
         nxt_mem[link_addr_ff] <= {1'b0, link_data_ff};
      end
      if (walk_rd.adj_en) begin
         adj_target <= tgt_mem[walk_rd.adj_addr];
         adj_next   <= nxt_mem[walk_rd.adj_addr];
      end
   end

   assign head_ptr = hv_ff[walk_rd.head_addr] ? {1'b0, head_ff[walk_rd.head_addr]}
                                              : bcf_pkg::PTR_NIL;
   assign busy     = link_ff;
   assign dropped  = drop_ff;

endmodule

FILE: hw/rtl/bcf_search.sv
module bcf_search (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [5:0]            vert_count,
   bcf_req_if.sink               req_chan,
   input  logic                  gs_busy,
   input  logic                  gs_dropped,
   input  logic [7:0]            head_ptr,
   input  logic [4:0]            adj_target,
   input  logic [7:0]            adj_next,
   input  logic                  q_done,
   output bcf_pkg::load_type     load_req,
   output bcf_pkg::walk_rd_type  walk_rd,
   output bcf_pkg::rec_wr_type   rec_wr,
   output bcf_pkg::flush_type    flush
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_NEXT_ROOT = 4'd1;
   localparam logic [3:0] S_STEP      = 4'd2;
   localparam logic [3:0] S_ADJ       = 4'd3;
   localparam logic [3:0] S_RET       = 4'd4;
   localparam logic [3:0] S_POP_START = 4'd5;
   localparam logic [3:0] S_POP_CHK   = 4'd6;
   localparam logic [3:0] S_POP_WR    = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;
   localparam logic [3:0] S_WAIT_Q    = 4'd9;

   typedef struct packed {
      logic [5:0] disc;
      logic [5:0] low;
      logic [4:0] par;
      logic       is_root;
      logic [7:0] cursor;
      logic [1:0] kids;
      logic [6:0] mark;
   } vrec_type;

   logic [3:0]  state_ff, state_in;
   logic [5:0]  root_ff, root_in;
   logic [4:0]  u_ff, u_in;
   vrec_type    cur_ff, cur_in;
   logic [6:0]  sp_ff, sp_in;
   logic [5:0]  clk_ff, clk_in;
   logic [5:0]  comp_ff, comp_in;
   logic [6:0]  emit_ff, emit_in;
   logic [6:0]  mark_ff, mark_in;
   logic        ret_ff, ret_in;
   logic        pdrop_ff, pdrop_in;
   logic [31:0] vis_ff, vis_in;

   vrec_type    rec_arr [bcf_pkg::MAX_VERTICES];
   logic [5:0]  disc_arr [bcf_pkg::MAX_VERTICES];
   logic [9:0]  edge_mem [bcf_pkg::MAX_EDGES];
   logic [9:0]  edge_q;

   logic        accept;
   logic        disc_we;
   logic [4:0]  disc_addr;
   logic        wb_we;
   vrec_type    wb_rec;
   logic        push_en;
   logic [9:0]  push_data;
   logic        edge_rd;
   logic [5:0]  edge_addr;
   vrec_type    prec;
   logic [5:0]  vdisc;
   logic [1:0]  kids_inc;
   logic        split;

   assign accept        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && !gs_busy;

   // record reads: parent on return, neighbor otherwise
   assign prec     = rec_arr[cur_ff.par];
   assign vdisc    = disc_arr[adj_target];
   assign kids_inc = (cur_ff.kids == 2'd2) ? 2'd2 : cur_ff.kids + 2'd1;
   assign split    = (prec.is_root && prec.kids == 2'd2) ||
                     (!prec.is_root && cur_ff.low >= prec.disc);

   always_comb begin
      state_in  = state_ff;
      root_in   = root_ff;
      u_in      = u_ff;
      cur_in    = cur_ff;
      sp_in     = sp_ff;
      clk_in    = clk_ff;
      comp_in   = comp_ff;
      emit_in   = emit_ff;
      mark_in   = mark_ff;
      ret_in    = ret_ff;
      pdrop_in  = pdrop_ff;
      vis_in    = vis_ff;
      disc_we   = 1'b0;
      disc_addr = adj_target;
      wb_we     = 1'b0;
      wb_rec    = cur_ff;
      push_en   = 1'b0;
      push_data = {u_ff, adj_target};
      edge_rd   = 1'b0;
      edge_addr = 6'(sp_ff - 7'd1);
      load_req.en          = 1'b0;
      load_req.from_vertex = req_chan.from_vertex;
      load_req.to_vertex   = req_chan.to_vertex;
      walk_rd.clear     = 1'b0;
      walk_rd.adj_en    = 1'b0;
      walk_rd.adj_addr  = cur_ff.cursor[6:0];
      walk_rd.head_addr = (state_ff == S_NEXT_ROOT) ? root_ff[4:0] : adj_target;
      rec_wr.wr   = 1'b0;
      rec_wr.addr = emit_ff[5:0];
      rec_wr.data = {edge_q[9:5], edge_q[4:0], comp_ff, sp_ff == mark_ff};
      flush.start   = 1'b0;
      flush.count   = emit_ff;
      flush.dropped = pdrop_ff || gs_dropped;

      case (state_ff)
         S_IDLE: begin
            if (accept && !req_chan.op) begin
               load_req.en = 1'b1;
            end else if (accept) begin
               vis_in   = '0;
               sp_in    = '0;
               clk_in   = '0;
               comp_in  = '0;
               emit_in  = '0;
               root_in  = '0;
               state_in = S_NEXT_ROOT;
            end
         end
         // pick the next unvisited root
         S_NEXT_ROOT: begin
            if (root_ff >= vert_count) begin
               state_in = S_DONE;
            end else if (vis_ff[root_ff[4:0]]) begin
               root_in = root_ff + 6'd1;
            end else begin
               clk_in         = clk_ff + 6'd1;
               disc_we        = 1'b1;
               disc_addr      = root_ff[4:0];
               u_in           = root_ff[4:0];
               cur_in.disc    = clk_in;
               cur_in.low     = clk_in;
               cur_in.par     = '0;
               cur_in.is_root = 1'b1;
               cur_in.cursor  = head_ptr;
               cur_in.kids    = '0;
               cur_in.mark    = '0;
               vis_in[root_ff[4:0]] = 1'b1;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (cur_ff.cursor[7]) begin
               state_in = S_RET;
            end else begin
               walk_rd.adj_en = 1'b1;
               state_in       = S_ADJ;
            end
         end
         // one adjacency entry of the current vertex
         S_ADJ: begin
            cur_in.cursor = adj_next;
            state_in      = S_STEP;
            if ({1'b0, adj_target} < vert_count) begin
               if (!vis_ff[adj_target]) begin
                  push_en        = 1'b1;
                  wb_we          = 1'b1;
                  wb_rec.cursor  = adj_next;
                  wb_rec.kids    = kids_inc;
                  clk_in         = clk_ff + 6'd1;
                  disc_we        = 1'b1;
                  u_in           = adj_target;
                  cur_in.disc    = clk_in;
                  cur_in.low     = clk_in;
                  cur_in.par     = u_ff;
                  cur_in.is_root = 1'b0;
                  cur_in.cursor  = head_ptr;
                  cur_in.kids    = '0;
                  cur_in.mark    = sp_ff;
                  vis_in[adj_target] = 1'b1;
               end else if (cur_ff.is_root || cur_ff.par != adj_target) begin
                  if (vdisc < cur_ff.low) begin
                     cur_in.low = vdisc;
                  end
                  if (vdisc < cur_ff.disc) begin
                     push_en = 1'b1;
                  end
               end
            end
         end
         // vertex finished: back to its parent, popping a component on a split, or for a root pop its last component
         S_RET: begin
            if (cur_ff.is_root) begin
               mark_in  = '0;
               ret_in   = 1'b0;
               state_in = S_POP_START;
            end else begin
               u_in   = cur_ff.par;
               cur_in = prec;
               if (cur_ff.low < prec.low) begin
                  cur_in.low = cur_ff.low;
               end
               if (split) begin
                  mark_in  = cur_ff.mark;
                  ret_in   = 1'b1;
                  state_in = S_POP_START;
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_POP_START: begin
            if (sp_ff <= mark_ff) begin
               state_in = ret_ff ? S_STEP : S_NEXT_ROOT;
            end else begin
               state_in = S_POP_CHK;
            end
         end
         // pop edges down to the mark, or until the result queue is full
         S_POP_CHK: begin
            if (sp_ff > mark_ff && emit_ff < 7'(bcf_pkg::MAX_EDGES)) begin
               edge_rd  = 1'b1;
               sp_in    = sp_ff - 7'd1;
               state_in = S_POP_WR;
            end else begin
               sp_in    = mark_ff;
               comp_in  = comp_ff + 6'd1;
               state_in = ret_ff ? S_STEP : S_NEXT_ROOT;
            end
         end
         S_POP_WR: begin
            rec_wr.wr = 1'b1;
            emit_in   = emit_ff + 7'd1;
            state_in  = S_POP_CHK;
         end
         S_DONE: begin
            walk_rd.clear = 1'b1;
            pdrop_in      = 1'b0;
            if (emit_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               flush.start = 1'b1;
               state_in    = S_WAIT_Q;
            end
         end
         S_WAIT_Q: begin
            if (q_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // full edge stack drops the push
      if (push_en && sp_ff >= 7'(bcf_pkg::MAX_EDGES)) begin
         pdrop_in = 1'b1;
      end else if (push_en) begin
         sp_in = sp_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
         clk_ff   <= '0;
         comp_ff  <= '0;
         emit_ff  <= '0;
         pdrop_ff <= 1'b0;
         vis_ff   <= '0;
         ret_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         clk_ff   <= clk_in;
         comp_ff  <= comp_in;
         emit_ff  <= emit_in;
         pdrop_ff <= pdrop_in;
         vis_ff   <= vis_in;
         ret_ff   <= ret_in;
      end
      root_ff <= root_in;
      u_ff    <= u_in;
      cur_ff  <= cur_in;
      mark_ff <= mark_in;
   end

   // vertex records and edge stack
   always_ff @(posedge clock) begin
      if (disc_we) begin
         disc_arr[disc_addr] <= clk_in;
      end
      if (wb_we) begin
         rec_arr[u_ff] <= wb_rec;
      end
      if (push_en && sp_ff < 7'(bcf_pkg::MAX_EDGES)) begin
         edge_mem[sp_ff[5:0]] <= push_data;
      end
      if (edge_rd) begin
         edge_q <= edge_mem[edge_addr];
      end
   end

`ifndef SYNTHESIS
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= 7'(bcf_pkg::MAX_EDGES))
      else $error("edge stack pointer past depth");
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emit_ff <= 7'(bcf_pkg::MAX_EDGES))
      else $error("result count past depth");
   a_pop_above_mark: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP_WR |-> sp_ff >= mark_ff)
      else $error("pop went below component mark");
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.op |=> state_ff == S_NEXT_ROOT && sp_ff == '0)
      else $error("run did not start cleanly");
`endif

endmodule

FILE: hw/rtl/bcf_result_queue.sv
module bcf_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  bcf_pkg::rec_wr_type  rec_wr,
   input  bcf_pkg::flush_type   flush,
   output logic                 q_done,
   bcf_rsp_if.source            rsp_chan
);

   localparam logic [1:0] Q_IDLE = 2'd0;
   localparam logic [1:0] Q_RD   = 2'd1;
   localparam logic [1:0] Q_LD   = 2'd2;
   localparam logic [1:0] Q_WAIT = 2'd3;

   bcf_pkg::rec_type rec_mem [bcf_pkg::MAX_EDGES];
   bcf_pkg::rec_type rd_q;
   bcf_pkg::rec_type out_ff;
   logic [1:0] state_ff, state_in;
   logic [5:0] idx_ff, idx_in;
   logic [6:0] cnt_ff;
   logic       drop_ff;
   logic       lor_ff;
   logic       last;

   assign last   = ({1'b0, idx_ff} == cnt_ff - 7'd1);
   assign q_done = (state_ff == Q_WAIT) && rsp_chan.ready && lor_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         Q_IDLE: begin
            if (flush.start) begin
               idx_in   = '0;
               state_in = Q_RD;
            end
         end
         Q_RD: begin
            state_in = Q_LD;
         end
         Q_LD: begin
            state_in = Q_WAIT;
         end
         Q_WAIT: begin
            if (rsp_chan.ready && lor_ff) begin
               state_in = Q_IDLE;
            end else if (rsp_chan.ready) begin
               idx_in   = idx_ff + 6'd1;
               state_in = Q_RD;
            end
         end
         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      if (flush.start) begin
         cnt_ff  <= flush.count;
         drop_ff <= flush.dropped;
      end
      if (state_ff == Q_LD) begin
         out_ff <= rd_q;
         lor_ff <= last;
      end
   end

   // result memory
   always_ff @(posedge clock) begin
      if (rec_wr.wr) begin
         rec_mem[rec_wr.addr] <= rec_wr.data;
      end
      if (state_ff == Q_RD) begin
         rd_q <= rec_mem[idx_ff];
      end
   end

   assign rsp_chan.valid             = (state_ff == Q_WAIT);
   assign rsp_chan.edge_first        = out_ff.edge_first;
   assign rsp_chan.edge_second       = out_ff.edge_second;
   assign rsp_chan.component_index   = out_ff.component_index;
   assign rsp_chan.last_in_component = out_ff.last_in_component;
   assign rsp_chan.last_of_run       = lor_ff;
   assign rsp_chan.entries_dropped   = drop_ff;

endmodule
